// ===== src/edd_pkg.sv =====
// ----------------------------------------------------------------------------
// edd_pkg: shared types and constants of the error diffusion dither
// Field types, register indexes, the white level and the clamp and
// divide helpers used by the per-pixel arithmetic.
// ----------------------------------------------------------------------------
package edd_pkg;

  // payload types
  typedef logic [7:0]         gray_t;
  typedef logic signed [15:0] coord_t;
  typedef logic [1:0]         cfg_idx_t;
  typedef logic [15:0]        cfg_data_t;

  // error shares as kept in the line store and the row registers
  typedef logic signed [3:0]  dr_share_t;   // down-right
  typedef logic signed [6:0]  dn_share_t;   // down
  typedef logic signed [5:0]  dl_share_t;   // down-left
  typedef logic signed [6:0]  rt_share_t;   // right
  typedef logic signed [7:0]  err_t;

  // register indexes
  localparam cfg_idx_t REG_IMAGE_WIDTH  = 2'd0;
  localparam cfg_idx_t REG_IMAGE_HEIGHT = 2'd1;
  localparam cfg_idx_t REG_ORIGIN_X     = 2'd2;
  localparam cfg_idx_t REG_ORIGIN_Y     = 2'd3;

  // register reset values
  localparam logic [9:0]  IMAGE_WIDTH_RST  = 10'd176;
  localparam logic [15:0] IMAGE_HEIGHT_RST = 16'd264;

  // quantizer levels
  localparam logic [8:0] WHITE_LEVEL = 9'd255;

  // add a signed share to a gray value, clamped to 0..255
  function automatic gray_t clamp_add(gray_t v, logic signed [7:0] s);
    logic signed [9:0] t;
    t = $signed({2'b00, v}) + 10'(s);
    if (t < 0) begin
      return 8'd0;
    end else if (t > 10'sd255) begin
      return 8'd255;
    end
    return t[7:0];
  endfunction

  // signed divide by 16 rounding toward zero
  function automatic logic signed [10:0] div16(logic signed [10:0] a);
    logic signed [10:0] b;
    b = a + (a[10] ? 11'sd15 : 11'sd0);
    return b >>> 4;
  endfunction

endpackage

// ===== src/edd_ifs.sv =====
// ----------------------------------------------------------------------------
// edd channel interfaces
// Gray pixel input, mono pixel output and register write channels.
// ----------------------------------------------------------------------------

// gray pixel stream
interface edd_gray_if;
  logic          valid;
  logic          ready;
  edd_pkg::gray_t gray_level;
  modport source (output valid, gray_level, input ready);
  modport sink   (input valid, gray_level, output ready);
endinterface

// dithered pixel stream with screen coordinates
interface edd_mono_if;
  logic            valid;
  logic            ready;
  edd_pkg::coord_t pixel_x;
  edd_pkg::coord_t pixel_y;
  logic            is_black;
  logic            frame_end;
  modport source (output valid, pixel_x, pixel_y, is_black, frame_end, input ready);
  modport sink   (input valid, pixel_x, pixel_y, is_black, frame_end, output ready);
endinterface

// register write channel
interface edd_cfg_if;
  logic               valid;
  logic               ready;
  edd_pkg::cfg_idx_t  index;
  edd_pkg::cfg_data_t data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/error_diffusion_dither.sv =====
// ----------------------------------------------------------------------------
// error_diffusion_dither: one-bit error diffusion of a gray raster
// Quantizes each gray pixel to black or white and spreads the error to the
// right and to the row below, with a per-column line store for the shares.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                  transfer
//  gray     in   gray_level                               valid & ready
//  mono     out  pixel_x, pixel_y, is_black, frame_end    valid & ready
//  cfg      in   index, data (width, height, origins)     valid & ready
//
//  One pixel per clock while the output is not stalled; a transferred pixel
//  is registered into the compute stage with its line store read, then
//  computed into the output register. The store has one read and one write
//  port per share memory; the right share is registered from pixel to pixel.
//  Reset restores the registers, clears position and pending shares; the
//  line store is not cleared since the first row never reads it.
//  A stalled result holds the output register; gray stays ready while the
//  compute stage is empty or moving.
// ----------------------------------------------------------------------------
module error_diffusion_dither #(
  parameter int MAX_WIDTH = 512
) (
  input logic        clk,
  input logic        rst,
  edd_gray_if.sink   gray,
  edd_mono_if.source mono,
  edd_cfg_if.sink    cfg
);
  import edd_pkg::*;

  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int CMPW = (AW + 2 > 11) ? AW + 2 : 11;

  // registers
  logic [9:0]  image_width;
  logic [15:0] image_height;
  coord_t      origin_x;
  coord_t      origin_y;

  // position of the next pixel
  logic [AW-1:0] col;
  logic [15:0]   row;

  // compute stage
  logic          s1_valid;
  logic [AW-1:0] s1_x;
  logic [15:0]   s1_y;
  gray_t         s1_gray;
  logic          s1_lc;
  logic          s1_lr;

  // row state
  rt_share_t right_share;
  dr_share_t pend_dr;

  // line store: down-right and down shares, down-left shares
  logic [10:0] mem_dd [MAX_WIDTH];
  logic [5:0]  mem_dl [MAX_WIDTH];
  logic [10:0] mem_dd_q;
  logic [5:0]  mem_dl_q;

  // forwarded store writes landing after the read
  logic        fwd_dd_v;
  logic [10:0] fwd_dd;
  logic        fwd_dl_v;
  logic [5:0]  fwd_dl;

  // pending zero for the down-left share of the last written column
  logic          z_valid;
  logic [AW-1:0] z_addr;

  // output register
  logic   o_valid;
  coord_t o_x;
  coord_t o_y;
  logic   o_black;
  logic   o_end;

  logic             acc;
  logic             s1_adv;
  logic [CMPW-1:0]  wfull;
  logic [CMPW-1:0]  ew;
  logic [15:0]      eh;
  logic             last_col_in;
  logic             last_row_in;
  logic [AW-1:0]    tgt;
  logic             dd_we;
  logic [10:0]      dd_wdata;
  logic             dlp_we;
  logic [AW-1:0]    dlp_addr;
  logic             z_set;
  logic             z_flush;
  logic             z_super;
  logic             dl_we;
  logic [AW-1:0]    dl_waddr;
  logic [5:0]       dl_wdata;
  logic [10:0]      dd_eff;
  logic [5:0]       dl_eff;
  gray_t            v1, v2, v3, v4;
  logic             black;
  logic [8:0]       err9;
  err_t             err;
  logic signed [10:0] e11;
  rt_share_t        rt_sh;
  dn_share_t        dn_sh;
  dl_share_t        dl_sh;
  dr_share_t        dr_sh;

  // handshakes
  assign cfg.ready  = 1'b1;
  assign s1_adv     = s1_valid && (!o_valid || mono.ready);
  assign gray.ready = !s1_valid || s1_adv;
  assign acc        = gray.valid && gray.ready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
      origin_x     <= '0;
      origin_y     <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_IMAGE_WIDTH:  image_width  <= cfg.data[9:0];
        REG_IMAGE_HEIGHT: image_height <= cfg.data;
        REG_ORIGIN_X:     origin_x     <= $signed(cfg.data);
        REG_ORIGIN_Y:     origin_y     <= $signed(cfg.data);
        default: ;
      endcase
    end
  end

  // effective size and edge flags for the incoming pixel
  always_comb begin
    wfull = CMPW'(image_width);
    if (wfull == '0) begin
      ew = CMPW'(1);
    end else if (wfull > CMPW'(MAX_WIDTH)) begin
      ew = CMPW'(MAX_WIDTH);
    end else begin
      ew = wfull;
    end
    eh          = (image_height == '0) ? 16'd1 : image_height;
    last_col_in = (CMPW'(col) + CMPW'(1)) >= ew;
    last_row_in = (17'(row) + 17'd1) >= 17'(eh);
  end

  // raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (acc) begin
      if (last_col_in) begin
        col <= '0;
        row <= last_row_in ? 16'd0 : row + 16'd1;
      end else begin
        col <= col + AW'(1);
      end
    end
  end

  // compute stage capture
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_x    <= col;
      s1_y    <= row;
      s1_gray <= gray.gray_level;
      s1_lc   <= last_col_in;
      s1_lr   <= last_row_in;
    end
  end

  // line store read for the incoming column
  always_ff @(posedge clk) begin
    if (acc) begin
      mem_dd_q <= mem_dd[col];
      mem_dl_q <= mem_dl[col];
    end
  end

  // line store write selection
  always_comb begin
    dd_we    = s1_adv && !s1_lr;
    dd_wdata = {pend_dr, dn_sh};
    dlp_we   = s1_adv && !s1_lr && (s1_x != '0);
    dlp_addr = s1_x - AW'(1);
    z_set    = s1_adv && !s1_lr;
    z_flush  = z_valid && !dlp_we;
    z_super  = z_valid && dlp_we && (z_addr == dlp_addr);
    dl_we    = dlp_we || z_flush;
    dl_waddr = dlp_we ? dlp_addr : z_addr;
    dl_wdata = dlp_we ? dl_sh : 6'd0;
  end

  always_ff @(posedge clk) begin
    if (dd_we) begin
      mem_dd[s1_x] <= dd_wdata;
    end
    if (dl_we) begin
      mem_dl[dl_waddr] <= dl_wdata;
    end
  end

  // pending down-left zero
  always_ff @(posedge clk) begin
    if (rst) begin
      z_valid <= 1'b0;
    end else if (z_set) begin
      z_valid <= 1'b1;
    end else if (z_flush || z_super) begin
      z_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (z_set) begin
      z_addr <= s1_x;
    end
  end

  // forward writes that hit the column being read; on one-pixel rows the
  // zero left below the previous pixel is still pending at that read
  assign tgt = acc ? col : s1_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_dd_v <= 1'b0;
      fwd_dl_v <= 1'b0;
    end else begin
      if (acc) begin
        fwd_dd_v <= dd_we && (s1_x == tgt);
        fwd_dl_v <= (dl_we && (dl_waddr == tgt)) || (z_set && (s1_x == tgt));
      end else begin
        if (dd_we && (s1_x == tgt)) begin
          fwd_dd_v <= 1'b1;
        end
        if (dl_we && (dl_waddr == tgt)) begin
          fwd_dl_v <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dd_we && (s1_x == tgt)) begin
      fwd_dd <= dd_wdata;
    end
    if (acc && z_set && (s1_x == tgt)) begin
      fwd_dl <= '0;
    end else if (dl_we && (dl_waddr == tgt)) begin
      fwd_dl <= dl_wdata;
    end
  end

  assign dd_eff = fwd_dd_v ? fwd_dd : mem_dd_q;
  assign dl_eff = fwd_dl_v ? fwd_dl : mem_dl_q;

  // working value, quantizer and error shares
  always_comb begin
    v1 = clamp_add(s1_gray, 8'($signed(dd_eff[10:7])));
    v2 = clamp_add(v1, 8'($signed(dd_eff[6:0])));
    v3 = clamp_add(v2, 8'($signed(dl_eff)));
    if (s1_y == '0) begin
      v3 = s1_gray;
    end
    v4 = (s1_x != '0) ? clamp_add(v3, 8'(right_share)) : v3;
    black = !v4[7];
    err9  = {1'b0, v4} - (black ? 9'd0 : WHITE_LEVEL);
    err   = $signed(err9[7:0]);
    e11   = 11'(err);
    rt_sh = 7'(div16(e11 * 11'sd7));
    dn_sh = 7'(div16(e11 * 11'sd5));
    dl_sh = 6'(div16(e11 * 11'sd3));
    dr_sh = 4'(div16(e11));
  end

  // row state
  always_ff @(posedge clk) begin
    if (rst) begin
      right_share <= '0;
      pend_dr     <= '0;
    end else if (s1_adv) begin
      right_share <= s1_lc ? 7'sd0 : rt_sh;
      if (s1_lc) begin
        pend_dr <= '0;
      end else if (!s1_lr) begin
        pend_dr <= dr_sh;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_adv) begin
      o_valid <= 1'b1;
    end else if (mono.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      o_x     <= origin_x + $signed(16'(s1_x));
      o_y     <= origin_y + $signed(s1_y);
      o_black <= black;
      o_end   <= s1_lc && s1_lr;
    end
  end

  assign mono.valid     = o_valid;
  assign mono.pixel_x   = o_x;
  assign mono.pixel_y   = o_y;
  assign mono.is_black  = o_black;
  assign mono.frame_end = o_end;

  // a pending down-left zero is never overwritten before it lands
  a_zero_kept: assert property (@(posedge clk) disable iff (rst)
    (z_valid && z_set) |-> (z_flush || z_super))
    else $error("pending down-left zero lost");

  // the row wraps after its last column
  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    (acc && last_col_in) |=> (col == '0))
    else $error("column counter did not wrap");

  // an empty output register never blocks the input
  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    !o_valid |-> gray.ready)
    else $error("input stalled with empty output register");

  // a transferred pixel reaches the compute stage
  a_stage_fill: assert property (@(posedge clk) disable iff (rst)
    acc |=> s1_valid)
    else $error("compute stage missed a pixel");

endmodule
